// ===== design/otrb_pkg.sv =====
// ----------------------------------------------------------------------------
// otrb_pkg
// Shared types and constants for the overwriting trace ring buffer.
// ----------------------------------------------------------------------------
package otrb_pkg;

  localparam int unsigned EntriesDef    = 32;
  localparam int unsigned QueueDepthDef = 4;
  localparam int unsigned SlotW         = 6;   // slot index width at the largest ring
  localparam int unsigned CntW          = 7;

  typedef enum logic [1:0] {
    CMD_EVENT  = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_EXPORT = 2'd2
  } cmd_e;

  typedef enum logic {
    JOB_WRITE  = 1'b0,
    JOB_EXPORT = 1'b1
  } job_kind_e;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_READ = 1'b1
  } back_state_e;

  typedef struct packed {
    logic [1:0]      cmd;
    logic [15:0]     event_type;
    logic [31:0]     arg_first;
    logic [31:0]     arg_second;
    logic [31:0]     time_stamp;
    logic [7:0]      cpu_id;
    logic [CntW-1:0] max_records;
  } in_t;

  typedef struct packed {
    logic            rec_valid;
    logic [31:0]     rec_time;
    logic [15:0]     rec_type;
    logic [7:0]      rec_cpu;
    logic            rec_overflow;
    logic [31:0]     rec_arg_first;
    logic [31:0]     rec_arg_second;
    logic [CntW-1:0] export_count;
    logic [31:0]     dropped_total;
    logic            last;
  } out_t;

  typedef struct packed {
    logic [31:0] time_stamp;
    logic [15:0] event_type;
    logic [7:0]  cpu_id;
    logic        overflow;
    logic [31:0] arg_first;
    logic [31:0] arg_second;
  } rec_t;

  typedef struct packed {
    job_kind_e        kind;
    logic [SlotW-1:0] slot;
    rec_t             rec;
    logic [CntW-1:0]  cnt;
    logic [31:0]      drop;
  } job_t;

endpackage

// ===== design/otrb_ram.sv =====
// ----------------------------------------------------------------------------
// otrb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module otrb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/otrb_front.sv =====
// ----------------------------------------------------------------------------
// otrb_front
// Command front end: keeps head and drop count, turns events and exports
// into jobs for the back end.
// ----------------------------------------------------------------------------
module otrb_front #(
  parameter int unsigned ENTRIES = otrb_pkg::EntriesDef,
  localparam int unsigned SW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  otrb_pkg::in_t  in_data_i,
  output logic           in_stall_o,
  output logic           q_push_o,
  output otrb_pkg::job_t q_job_o,
  input  logic           q_full_i
);
  import otrb_pkg::*;

  logic [31:0]     head_q, head_d;
  logic [31:0]     drop_q, drop_d;
  logic [SW-1:0]   wslot_q, wslot_d;
  logic            accept;
  logic            full;
  logic [CntW-1:0] avail, n, ws_ext, start;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign full       = head_q >= 32'(ENTRIES);

  assign avail  = full ? CntW'(ENTRIES) : head_q[CntW-1:0];
  assign n      = (avail < in_data_i.max_records) ? avail : in_data_i.max_records;
  assign ws_ext = CntW'(wslot_q);
  assign start  = (ws_ext >= n) ? (ws_ext - n) : (ws_ext + CntW'(ENTRIES) - n);

  always_comb begin
    head_d   = head_q;
    drop_d   = drop_q;
    wslot_d  = wslot_q;
    q_push_o = 1'b0;
    q_job_o  = '0;
    if (accept) begin
      case (in_data_i.cmd)
        CMD_EVENT: begin
          q_push_o                   = 1'b1;
          q_job_o.kind               = JOB_WRITE;
          q_job_o.slot               = SlotW'(wslot_q);
          q_job_o.rec.time_stamp     = in_data_i.time_stamp;
          q_job_o.rec.event_type     = in_data_i.event_type;
          q_job_o.rec.cpu_id         = in_data_i.cpu_id;
          q_job_o.rec.overflow       = full;
          q_job_o.rec.arg_first      = in_data_i.arg_first;
          q_job_o.rec.arg_second     = in_data_i.arg_second;
          head_d                     = head_q + 32'd1;
          if (full) begin
            drop_d = drop_q + 32'd1;
          end
          if (head_q == '1 || wslot_q == SW'(ENTRIES - 1)) begin
            wslot_d = '0;
          end else begin
            wslot_d = wslot_q + 1'b1;
          end
        end
        CMD_CLEAR: begin
          head_d  = '0;
          drop_d  = '0;
          wslot_d = '0;
        end
        CMD_EXPORT: begin
          q_push_o     = 1'b1;
          q_job_o.kind = JOB_EXPORT;
          q_job_o.slot = start[SlotW-1:0];
          q_job_o.cnt  = n;
          q_job_o.drop = drop_q;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      drop_q  <= '0;
      wslot_q <= '0;
    end else begin
      head_q  <= head_d;
      drop_q  <= drop_d;
      wslot_q <= wslot_d;
    end
  end

endmodule

// ===== design/otrb_queue.sv =====
// ----------------------------------------------------------------------------
// otrb_queue
// Short job queue between front and back end.
// ----------------------------------------------------------------------------
module otrb_queue #(
  parameter int unsigned DEPTH = otrb_pkg::QueueDepthDef,
  localparam int unsigned PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned NW   = $clog2(DEPTH + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  otrb_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output otrb_pkg::job_t job_o,
  output logic           empty_o
);
  import otrb_pkg::*;

  job_t          buf_q [DEPTH];
  logic [PW-1:0] wptr_q, rptr_q;
  logic [NW-1:0] num_q;

  assign full_o  = num_q == NW'(DEPTH);
  assign empty_o = num_q == '0;
  assign job_o   = buf_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      num_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        num_q <= num_q + 1'b1;
      end else if (pop_i && !push_i) begin
        num_q <= num_q - 1'b1;
      end
    end
  end

endmodule

// ===== design/otrb_back.sv =====
// ----------------------------------------------------------------------------
// otrb_back
// Back end: carries out slot writes and export read runs in order, and
// holds the result register.
// ----------------------------------------------------------------------------
module otrb_back #(
  parameter int unsigned ENTRIES = otrb_pkg::EntriesDef,
  localparam int unsigned SW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int unsigned RW     = $bits(otrb_pkg::rec_t)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  otrb_pkg::job_t q_job_i,
  input  logic           q_empty_i,
  output logic           q_pop_o,
  output logic           ram_we_o,
  output logic [SW-1:0]  ram_waddr_o,
  output logic [RW-1:0]  ram_wdata_o,
  output logic           ram_re_o,
  output logic [SW-1:0]  ram_raddr_o,
  input  logic [RW-1:0]  ram_rdata_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output otrb_pkg::out_t out_data_o
);
  import otrb_pkg::*;

  back_state_e     state_q, state_d;
  logic [CntW-1:0] rem_q, jcnt_q, pcnt_q;
  logic [31:0]     jdrop_q, pdrop_q;
  logic [SW-1:0]   addr_q;
  logic            pend_q, plast_q;
  logic            out_v_q;
  out_t            out_q;
  logic            slot_free, consume, issue, load_empty, load_job;
  rec_t            rd_rec;

  assign slot_free = !out_v_q || !out_stall_i;
  assign consume   = pend_q && slot_free;
  assign rd_rec    = rec_t'(ram_rdata_i);

  assign ram_waddr_o = q_job_i.slot[SW-1:0];
  assign ram_wdata_o = RW'(q_job_i.rec);
  assign ram_raddr_o = addr_q;

  // outputs of the sequencer
  always_comb begin
    q_pop_o    = 1'b0;
    ram_we_o   = 1'b0;
    ram_re_o   = 1'b0;
    issue      = 1'b0;
    load_empty = 1'b0;
    load_job   = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          if (q_job_i.kind == JOB_WRITE) begin
            q_pop_o  = 1'b1;
            ram_we_o = 1'b1;
          end else if (q_job_i.cnt == '0) begin
            if (slot_free && !pend_q) begin
              q_pop_o    = 1'b1;
              load_empty = 1'b1;
            end
          end else begin
            q_pop_o  = 1'b1;
            load_job = 1'b1;
          end
        end
      end
      BK_READ: begin
        issue    = !pend_q || consume;
        ram_re_o = issue;
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (load_job) begin
          state_d = BK_READ;
        end
      end
      BK_READ: begin
        if (issue && rem_q == CntW'(1)) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      pend_q  <= 1'b0;
      out_v_q <= 1'b0;
      rem_q   <= '0;
    end else begin
      state_q <= state_d;
      if (issue) begin
        pend_q <= 1'b1;
      end else if (consume) begin
        pend_q <= 1'b0;
      end
      if (consume || load_empty) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
      if (load_job) begin
        rem_q <= q_job_i.cnt;
      end else if (issue) begin
        rem_q <= rem_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_job) begin
      addr_q  <= q_job_i.slot[SW-1:0];
      jcnt_q  <= q_job_i.cnt;
      jdrop_q <= q_job_i.drop;
    end else if (issue) begin
      addr_q <= (addr_q == SW'(ENTRIES - 1)) ? '0 : addr_q + 1'b1;
    end
    if (issue) begin
      pcnt_q  <= jcnt_q;
      pdrop_q <= jdrop_q;
      plast_q <= rem_q == CntW'(1);
    end
    if (consume) begin
      out_q.rec_valid      <= 1'b1;
      out_q.rec_time       <= rd_rec.time_stamp;
      out_q.rec_type       <= rd_rec.event_type;
      out_q.rec_cpu        <= rd_rec.cpu_id;
      out_q.rec_overflow   <= rd_rec.overflow;
      out_q.rec_arg_first  <= rd_rec.arg_first;
      out_q.rec_arg_second <= rd_rec.arg_second;
      out_q.export_count   <= pcnt_q;
      out_q.dropped_total  <= pdrop_q;
      out_q.last           <= plast_q;
    end else if (load_empty) begin
      out_q.rec_valid      <= 1'b0;
      out_q.rec_time       <= '0;
      out_q.rec_type       <= '0;
      out_q.rec_cpu        <= '0;
      out_q.rec_overflow   <= 1'b0;
      out_q.rec_arg_first  <= '0;
      out_q.rec_arg_second <= '0;
      out_q.export_count   <= '0;
      out_q.dropped_total  <= q_job_i.drop;
      out_q.last           <= 1'b1;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/overwriting_trace_ring_buffer.sv =====
// ----------------------------------------------------------------------------
// overwriting_trace_ring_buffer
// Trace ring that records events, clears its head and drop count, and
// exports the most recent records oldest first.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_stall_o | in_data_i  (otrb_pkg::in_t)
//  out     | output    | out_valid_o/out_stall_i | out_data_o (otrb_pkg::out_t)
//
//  Clear and unused commands are handled in the front end only.
//  An event is queued by the front end and written to its slot by the back end.
//  An export of n records is set up in the back end, then read record by record,
//  paced by the single RAM read port; an empty export gives one result.
//  Reset clears head, drop count, queue and control; slot contents are kept.
//  A stalled output holds the record in the RAM read register and pauses reads.
// ----------------------------------------------------------------------------
module overwriting_trace_ring_buffer #(
  parameter int unsigned ENTRIES     = otrb_pkg::EntriesDef,
  parameter int unsigned QUEUE_DEPTH = otrb_pkg::QueueDepthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  otrb_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output otrb_pkg::out_t out_data_o
);
  import otrb_pkg::*;

  localparam int unsigned SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned RW = $bits(rec_t);

  logic          q_push, q_full, q_pop, q_empty;
  job_t          push_job, head_job;
  logic          ram_we, ram_re;
  logic [SW-1:0] ram_waddr, ram_raddr;
  logic [RW-1:0] ram_wdata, ram_rdata;

  otrb_front #(
    .ENTRIES(ENTRIES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .q_push_o   (q_push),
    .q_job_o    (push_job),
    .q_full_i   (q_full)
  );

  otrb_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .job_o   (head_job),
    .empty_o (q_empty)
  );

  otrb_back #(
    .ENTRIES(ENTRIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_job_i     (head_job),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  otrb_ram #(
    .WIDTH(RW),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

// ===== design/otrb_checker.sv =====
// ----------------------------------------------------------------------------
// otrb_checker
// Port-level checks for the trace ring buffer, bound to the top level.
// ----------------------------------------------------------------------------
module otrb_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input otrb_pkg::out_t out_data_o
);
  import otrb_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output transfer changed");

  a_empty_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.rec_valid |->
      out_data_o.export_count == '0 && out_data_o.last &&
      out_data_o.rec_time == '0 && out_data_o.rec_arg_first == '0)
    else $error("empty export result malformed");

  a_rec_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.rec_valid |-> out_data_o.export_count != '0)
    else $error("record result with zero count");

  a_run_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_data_o.rec_valid && !out_data_o.last
      ##1 out_valid_o |->
      out_data_o.rec_valid &&
      out_data_o.export_count == $past(out_data_o.export_count) &&
      out_data_o.dropped_total == $past(out_data_o.dropped_total))
    else $error("export run broken before its last record");

endmodule

bind overwriting_trace_ring_buffer otrb_checker u_otrb_checker (.*);

// ===== tb/tb_overwriting_trace_ring_buffer.sv =====
// ----------------------------------------------------------------------------
// tb_overwriting_trace_ring_buffer
// Self-checking bench for the trace ring. Event, clear, export and unused
// commands are sent on the input channel, each accepted transfer updates a
// shadow ring, and every export record on the output channel is compared
// field by field, in order, with the record the shadow ring predicts.
// Both channels idle and stall at random, apart from one calm stretch.
// ----------------------------------------------------------------------------
module tb_overwriting_trace_ring_buffer;
  import otrb_pkg::*;

  localparam int unsigned Entries     = EntriesDef;
  localparam logic [1:0]  CmdUnused   = 2'd3;
  localparam int unsigned IdlePct     = 23;
  localparam int unsigned RandomItems = 230;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned MaxPrinted  = 100;

  class trace_ring_scoreboard;
    rec_t        ring_slots [Entries];
    logic [31:0] head_count;
    logic [31:0] drop_count;
    out_t        expected_records [$];
    int unsigned mismatches;
    int unsigned records_seen;

    function new();
      head_count   = '0;
      drop_count   = '0;
      mismatches   = 0;
      records_seen = 0;
    endfunction

    task report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MaxPrinted) begin
        $display("MISMATCH: %s", msg);
      end
    endtask

    function void note_transfer(input in_t it);
      rec_t        rec;
      out_t        res;
      logic [31:0] n;
      logic [31:0] first;
      case (it.cmd)
        CMD_EVENT: begin
          rec.time_stamp = it.time_stamp;
          rec.event_type = it.event_type;
          rec.cpu_id     = it.cpu_id;
          rec.arg_first  = it.arg_first;
          rec.arg_second = it.arg_second;
          rec.overflow   = (head_count >= Entries);
          if (rec.overflow) begin
            drop_count = drop_count + 1;
          end
          ring_slots[head_count % Entries] = rec;
          head_count = head_count + 1;
        end
        CMD_CLEAR: begin
          head_count = '0;
          drop_count = '0;
        end
        CMD_EXPORT: begin
          n = (head_count < Entries) ? head_count : Entries;
          if (n > it.max_records) begin
            n = it.max_records;
          end
          if (n == 0) begin
            res               = '0;
            res.dropped_total = drop_count;
            res.last          = 1'b1;
            expected_records.push_back(res);
          end else begin
            first = head_count - n;
            for (int unsigned i = 0; i < n; i++) begin
              rec                = ring_slots[(first + i) % Entries];
              res.rec_valid      = 1'b1;
              res.rec_time       = rec.time_stamp;
              res.rec_type       = rec.event_type;
              res.rec_cpu        = rec.cpu_id;
              res.rec_overflow   = rec.overflow;
              res.rec_arg_first  = rec.arg_first;
              res.rec_arg_second = rec.arg_second;
              res.export_count   = n[CntW-1:0];
              res.dropped_total  = drop_count;
              res.last           = (i + 1 == n);
              expected_records.push_back(res);
            end
          end
        end
        default: ;
      endcase
    endfunction

    task check_record(input out_t got);
      out_t  want;
      string bad;
      if (expected_records.size() == 0) begin
        report_mismatch($sformatf("unexpected record %h", got));
      end else begin
        want = expected_records.pop_front();
        bad  = "";
        if (got.rec_valid !== want.rec_valid) bad = {bad, " rec_valid"};
        if (got.rec_time !== want.rec_time) bad = {bad, " rec_time"};
        if (got.rec_type !== want.rec_type) bad = {bad, " rec_type"};
        if (got.rec_cpu !== want.rec_cpu) bad = {bad, " rec_cpu"};
        if (got.rec_overflow !== want.rec_overflow) bad = {bad, " rec_overflow"};
        if (got.rec_arg_first !== want.rec_arg_first) bad = {bad, " rec_arg_first"};
        if (got.rec_arg_second !== want.rec_arg_second) bad = {bad, " rec_arg_second"};
        if (got.export_count !== want.export_count) bad = {bad, " export_count"};
        if (got.dropped_total !== want.dropped_total) bad = {bad, " dropped_total"};
        if (got.last !== want.last) bad = {bad, " last"};
        if (bad != "") begin
          report_mismatch($sformatf("record %0d:%s (exp %h got %h)",
                                    records_seen, bad, want, got));
        end
        records_seen++;
      end
    endtask
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  in_t         in_data_i   = '0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  out_t        out_data_o;
  logic        calm        = 1'b0;
  int unsigned cycle_count = 0;

  trace_ring_scoreboard ring_sb = new();

  overwriting_trace_ring_buffer #(
    .ENTRIES(Entries)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        ring_sb.check_record(out_data_o);
      end
      if (in_valid_i && !in_stall_o) begin
        ring_sb.note_transfer(in_data_i);
      end
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < IdlePct);
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CntW-1:0] pick_limit();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) return CntW'($urandom_range(8));
    else if (r < 75) return CntW'($urandom_range(40, 9));
    else if (r < 93) return CntW'($urandom_range(64, 41));
    else return CntW'($urandom_range(127, 65));
  endfunction

  function automatic in_t pick_item(input logic [1:0] cmd, input logic [CntW-1:0] lim);
    in_t it;
    it.cmd         = cmd;
    it.event_type  = 16'(pick_word());
    it.arg_first   = pick_word();
    it.arg_second  = pick_word();
    it.time_stamp  = pick_word();
    it.cpu_id      = 8'(pick_word());
    it.max_records = lim;
    return it;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(input in_t it);
    logic taken;
    while (!calm && ($urandom_range(99) < IdlePct)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !in_stall_o;
      @(negedge clk_i);
    end
  endtask

  initial begin
    in_t         item;
    int unsigned sent;
    int unsigned run_len;
    int unsigned roll;
    logic [1:0]  cmd;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty ring, unused code, field extremes, limits, clear
    send_item(pick_item(CMD_EXPORT, 7'd5));
    send_item(pick_item(CmdUnused, 7'd3));
    item = '1;
    item.cmd = CMD_EVENT;
    send_item(item);
    item = '0;
    item.cmd = CMD_EVENT;
    send_item(item);
    send_item(pick_item(CMD_EVENT, 7'd64));
    send_item(pick_item(CMD_EXPORT, 7'd0));
    send_item(pick_item(CMD_EXPORT, 7'd2));
    send_item(pick_item(CMD_EXPORT, 7'd64));
    send_item(pick_item(CMD_EXPORT, 7'd127));
    send_item(pick_item(CMD_CLEAR, 7'd9));
    send_item(pick_item(CMD_EXPORT, 7'd10));
    repeat (4) send_item(pick_item(CMD_EVENT, 7'd0));
    send_item(pick_item(CMD_EXPORT, 7'd1));
    send_item(pick_item(CMD_EXPORT, 7'd4));

    // random episodes, each opened by a clear; the longer ones wrap the ring
    sent = 0;
    while (sent < RandomItems) begin
      send_item(pick_item(CMD_CLEAR, pick_limit()));
      sent++;
      run_len = $urandom_range(100, 15);
      for (int unsigned k = 0; k < run_len && sent < RandomItems; k++) begin
        calm <= (sent >= 90 && sent < 150);
        roll = $urandom_range(99);
        if (roll < 62) cmd = CMD_EVENT;
        else if (roll < 92) cmd = CMD_EXPORT;
        else if (roll < 94) cmd = CMD_CLEAR;
        else cmd = CmdUnused;
        send_item(pick_item(cmd, pick_limit()));
        if (cmd != CmdUnused) sent++;
      end
    end
    in_valid_i <= 1'b0;
    calm       <= 1'b0;

    while (ring_sb.expected_records.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (ring_sb.mismatches == 0 && ring_sb.expected_records.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/otrb_pkg.sv
design/otrb_ram.sv
design/otrb_front.sv
design/otrb_queue.sv
design/otrb_back.sv
design/overwriting_trace_ring_buffer.sv
design/otrb_checker.sv
tb/tb_overwriting_trace_ring_buffer.sv
